### design/tlsf_pkg.sv
// ----------------------------------------------------------------------------
// tlsf_pkg
// Shared types, character codes and the trigraph lookup for the filter.
// ----------------------------------------------------------------------------
package tlsf_pkg;

    typedef logic [7:0] char_t;

    // Result buffer depth; at least the most result items one input item can cause
    localparam int unsigned MaxResults = 5;
    // Most characters stage one can hand to the splice stage for one item
    localparam int unsigned MaxStageOne = 3;

    localparam int unsigned ResIdxWidth = $clog2(MaxResults);
    localparam int unsigned ResCntWidth = $clog2(MaxResults + 1);

    typedef logic [ResIdxWidth-1:0] res_idx_t;
    typedef logic [ResCntWidth-1:0] res_cnt_t;

    localparam char_t ChQuestion  = 8'h3F;
    localparam char_t ChBackslash = 8'h5C;
    localparam char_t ChNewline   = 8'h0A;
    localparam char_t ChNone      = 8'h00;

    // Replacement for the byte after two question marks; ChNone if none
    function automatic char_t trigraph_map(input char_t c);
        char_t rep;
        unique case (c)
            8'h3D:   rep = 8'h23;   // =  -> #
            8'h28:   rep = 8'h5B;   // (  -> [
            8'h2F:   rep = 8'h5C;   // /  -> backslash
            8'h29:   rep = 8'h5D;   // )  -> ]
            8'h27:   rep = 8'h5E;   // '  -> ^
            8'h3C:   rep = 8'h7B;   // <  -> {
            8'h21:   rep = 8'h7C;   // !  -> |
            8'h3E:   rep = 8'h7D;   // >  -> }
            8'h2D:   rep = 8'h7E;   // -  -> ~
            default: rep = ChNone;
        endcase
        return rep;
    endfunction

endpackage

### design/trigraph_and_line_splice_filter.sv
// Flow: an accepted item is registered, translated when the result buffer
// frees and loaded into it, and its first result is then offered.
// Throughput: one item per cycle while each item yields at most one result
// and out_ready holds; a multi-result item holds the buffer until drained.
// Reset: held question marks and held backslash clear, trigraph_enable = 1,
// both channels empty.
// ----------------------------------------------------------------------------
// trigraph_and_line_splice_filter
// Byte stream filter: ANSI trigraph replacement (switchable) followed by removal of
// backslash-newline splices, with flush of held characters at end of text.
// ----------------------------------------------------------------------------
module trigraph_and_line_splice_filter (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       last_out
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic trigraph_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigraph_enable_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            trigraph_enable_reg <= cfg_write_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register: decouples the input handshake from result draining
    // ------------------------------------------------------------------
    logic             in_valid_reg;
    tlsf_pkg::char_t  in_byte_reg;
    logic             in_eot_reg;

    // Filter state carried between items
    logic [1:0]       held_q_reg;
    logic             held_bs_reg;

    // Result buffer: up to MaxResults items from one input item, drained in
    // order. Each entry has a fixed slot; the read pointer walks it.
    tlsf_pkg::char_t                       res_byte_reg [tlsf_pkg::MaxResults];
    logic [tlsf_pkg::MaxResults-1:0]       res_has_reg;
    tlsf_pkg::res_cnt_t                    res_cnt_reg;
    tlsf_pkg::res_idx_t                    res_idx_reg;
    logic                                  res_eot_reg;

    logic out_take;
    logic last_entry;
    logic last_take;
    logic buf_free;
    logic load_item;

    assign out_valid  = (res_cnt_reg != '0);
    assign out_take   = out_valid && out_ready;
    // Read pointer sits on the final entry of the buffer
    assign last_entry = (tlsf_pkg::res_cnt_t'(res_idx_reg) ==
                         (res_cnt_reg - tlsf_pkg::res_cnt_t'(1)));
    // Final entry of the buffer leaves this cycle
    assign last_take  = out_take && last_entry;
    assign buf_free   = (res_cnt_reg == '0) || last_take;
    // The held item moves into the result buffer whenever the buffer frees
    assign load_item  = in_valid_reg && buf_free;
    assign in_ready   = !in_valid_reg || load_item;

    assign out_byte  = res_byte_reg[res_idx_reg];
    assign has_byte  = res_has_reg[res_idx_reg];
    assign last_out  = res_eot_reg && last_entry;

    // ------------------------------------------------------------------
    // Single-pass translation of the registered item
    //   stage one: trigraph handling -> list of up to 3 characters
    //   stage two: splice removal over that list -> up to 4 results
    // ------------------------------------------------------------------
    tlsf_pkg::char_t                 s1_char [tlsf_pkg::MaxStageOne];
    logic [tlsf_pkg::MaxStageOne-1:0] s1_vld;
    logic [1:0]                      held_q_next;
    logic                            held_bs_next;
    tlsf_pkg::char_t                 res_byte_next [tlsf_pkg::MaxResults];
    logic [tlsf_pkg::MaxResults-1:0] res_has_next;
    tlsf_pkg::res_cnt_t              res_cnt_next;

    always_comb
    begin
        tlsf_pkg::char_t rep;
        logic [1:0]      n1;
        logic [1:0]      hq;
        logic            flush;

        rep   = tlsf_pkg::trigraph_map(in_byte_reg);
        n1    = 2'd0;
        hq    = held_q_reg;
        flush = 1'b0;
        for (int i = 0; i < tlsf_pkg::MaxStageOne; i++)
        begin
            s1_char[i] = tlsf_pkg::ChQuestion;
            s1_vld[i]  = 1'b0;
        end

        // Stage one. Held question marks are always sent first, so the
        // list is "hq question marks, then at most one other character".
        if (!trigraph_enable_reg)
        begin
            flush = 1'b1;
        end
        else if (in_byte_reg == tlsf_pkg::ChQuestion)
        begin
            if (hq == 2'd2)
            begin
                // long run: oldest question mark moves on, two stay held
                s1_vld[0] = 1'b1;
                n1        = 2'd1;
            end
            else
            begin
                hq = hq + 2'd1;
            end
        end
        else if ((hq == 2'd2) && (rep != tlsf_pkg::ChNone))
        begin
            s1_char[0] = rep;
            s1_vld[0]  = 1'b1;
            n1         = 2'd1;
            hq         = 2'd0;
        end
        else
        begin
            flush = 1'b1;
        end

        if (flush)
        begin
            // held question marks, then the byte itself
            if (hq != 2'd0)
            begin
                s1_vld[0] = 1'b1;
            end
            if (hq == 2'd2)
            begin
                s1_vld[1] = 1'b1;
            end
            s1_char[hq] = in_byte_reg;
            s1_vld[hq]  = 1'b1;
            n1          = hq + 2'd1;
            hq          = 2'd0;
        end

        // End of text flushes the remaining question marks
        if (in_eot_reg)
        begin
            if (hq != 2'd0)
            begin
                s1_vld[n1] = 1'b1;
            end
            if (hq == 2'd2)
            begin
                s1_vld[n1 + 2'd1] = 1'b1;
            end
            hq = 2'd0;
        end
        held_q_next = hq;
    end

    always_comb
    begin
        logic               bs;
        tlsf_pkg::res_cnt_t n;
        tlsf_pkg::char_t    c;

        bs = held_bs_reg;
        n  = '0;
        c  = tlsf_pkg::ChNone;
        for (int i = 0; i < tlsf_pkg::MaxResults; i++)
        begin
            res_byte_next[i] = tlsf_pkg::ChNone;
        end
        res_has_next = '1;

        // Splice removal, one stage-one character per step
        for (int i = 0; i < tlsf_pkg::MaxStageOne; i++)
        begin
            c = s1_char[i];
            if (s1_vld[i])
            begin
                if (bs)
                begin
                    if (c == tlsf_pkg::ChNewline)
                    begin
                        bs = 1'b0;
                    end
                    else if (c == tlsf_pkg::ChBackslash)
                    begin
                        // first backslash goes on, second stays held
                        res_byte_next[n[tlsf_pkg::ResIdxWidth-1:0]] = tlsf_pkg::ChBackslash;
                        n = n + tlsf_pkg::res_cnt_t'(1);
                    end
                    else
                    begin
                        res_byte_next[n[tlsf_pkg::ResIdxWidth-1:0]] = tlsf_pkg::ChBackslash;
                        n = n + tlsf_pkg::res_cnt_t'(1);
                        res_byte_next[n[tlsf_pkg::ResIdxWidth-1:0]] = c;
                        n = n + tlsf_pkg::res_cnt_t'(1);
                        bs = 1'b0;
                    end
                end
                else if (c == tlsf_pkg::ChBackslash)
                begin
                    bs = 1'b1;
                end
                else
                begin
                    res_byte_next[n[tlsf_pkg::ResIdxWidth-1:0]] = c;
                    n = n + tlsf_pkg::res_cnt_t'(1);
                end
            end
        end

        if (in_eot_reg)
        begin
            // held backslash is flushed as is
            if (bs)
            begin
                res_byte_next[n[tlsf_pkg::ResIdxWidth-1:0]] = tlsf_pkg::ChBackslash;
                n  = n + tlsf_pkg::res_cnt_t'(1);
                bs = 1'b0;
            end
            // nothing produced: bare end marker
            if (n == '0)
            begin
                res_has_next[0] = 1'b0;
                n = tlsf_pkg::res_cnt_t'(1);
            end
        end

        held_bs_next = bs;
        res_cnt_next = n;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            held_q_reg   <= 2'd0;
            held_bs_reg  <= 1'b0;
            res_cnt_reg  <= '0;
            res_idx_reg  <= '0;
            res_eot_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (load_item)
            begin
                in_valid_reg <= 1'b0;
            end

            if (load_item)
            begin
                held_q_reg  <= held_q_next;
                held_bs_reg <= held_bs_next;
                res_cnt_reg <= res_cnt_next;
                res_idx_reg <= '0;
                res_eot_reg <= in_eot_reg;
            end
            else if (last_take)
            begin
                res_cnt_reg <= '0;
                res_idx_reg <= '0;
            end
            else if (out_take)
            begin
                res_idx_reg <= res_idx_reg + tlsf_pkg::res_idx_t'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_eot_reg  <= end_of_text;
        end
        if (load_item)
        begin
            res_byte_reg <= res_byte_next;
            res_has_reg  <= res_has_next;
        end
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes into the trigraph and line splice filter through a
// random-gap driver, checks every result item against a local prediction of
// the filter, and steps the trigraph switch between phases of the run.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Run control
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 10;     // margin for the pipe to drain the last item's results, up to four
    localparam int unsigned MaxReports  = 10;
    localparam int unsigned PhaseItems  = 42;
    localparam int unsigned IdlePct     = 30;

    // Third characters of the nine trigraphs
    localparam tlsf_pkg::char_t TrigraphTail [9] =
        '{"=", "(", "/", ")", "'", "<", "!", ">", "-"};

    typedef struct packed {
        tlsf_pkg::char_t data;
        logic            eot;
    } text_item_t;

    typedef struct packed {
        tlsf_pkg::char_t data;
        logic            has;
        logic            is_last;
    } text_result_t;

    // ------------------------------------------------------------------------
    // DUT signals, all known from time zero
    // ------------------------------------------------------------------------
    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_write_en   = 1'b0;
    logic       cfg_write_data = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte        = 8'h00;
    logic       end_of_text    = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_out;

    trigraph_and_line_splice_filter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .has_byte       (has_byte),
        .last_out       (last_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------------
    text_item_t   byte_queue [$];   // items waiting for the driver
    text_result_t text_due [$];     // predicted result items, oldest first
    text_result_t step_out [$];     // results of the item being predicted
    text_result_t due_head;

    int unsigned idle_pct      = IdlePct;
    int unsigned errors        = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned texts_closed  = 0;
    int unsigned trigraphs_hit = 0;
    int unsigned splices_cut   = 0;
    int unsigned switch_writes = 0;
    int unsigned cycles        = 0;

    // Predicted filter state; reset values of the block
    bit         trig_en = 1'b1;
    logic [1:0] q_held  = 2'd0;
    bit         bs_held = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction of the filter
    // ------------------------------------------------------------------------
    function automatic tlsf_pkg::char_t trigraph_replacement(tlsf_pkg::char_t c);
        case (c)
            "=":     return "#";
            "(":     return "[";
            "/":     return "\\";
            ")":     return "]";
            "'":     return "^";
            "<":     return "{";
            "!":     return "|";
            ">":     return "}";
            "-":     return "~";
            default: return tlsf_pkg::ChNone;
        endcase
    endfunction

    function automatic void emit_char(tlsf_pkg::char_t c);
        step_out.push_back('{data: c, has: 1'b1, is_last: 1'b0});
    endfunction

    // Stage two: a backslash waits one character; a newline after it cancels both
    function automatic void splice_char(tlsf_pkg::char_t c);
        if (bs_held)
        begin
            if (c == tlsf_pkg::ChNewline)
            begin
                bs_held = 1'b0;
                splices_cut++;
            end
            else if (c == tlsf_pkg::ChBackslash)
                emit_char(tlsf_pkg::ChBackslash);     // first goes on, second stays held
            else
            begin
                emit_char(tlsf_pkg::ChBackslash);
                emit_char(c);
                bs_held = 1'b0;
            end
        end
        else if (c == tlsf_pkg::ChBackslash)
            bs_held = 1'b1;
        else
            emit_char(c);
    endfunction

    function automatic void release_questions();
        while (q_held != 2'd0)
        begin
            splice_char(tlsf_pkg::ChQuestion);
            q_held--;
        end
    endfunction

    // Stage one plus end-of-text flush; appends the item's results to text_due
    function automatic void filter_byte(tlsf_pkg::char_t c, logic eot);
        tlsf_pkg::char_t rep;
        step_out.delete();
        if (!trig_en)
        begin
            release_questions();
            splice_char(c);
        end
        else if (c == tlsf_pkg::ChQuestion)
        begin
            // a long run keeps the newest two held and pushes the oldest on
            if (q_held < 2'd2)
                q_held++;
            else
                splice_char(tlsf_pkg::ChQuestion);
        end
        else
        begin
            rep = (q_held == 2'd2) ? trigraph_replacement(c) : tlsf_pkg::ChNone;
            if (rep != tlsf_pkg::ChNone)
            begin
                q_held = 2'd0;
                trigraphs_hit++;
                splice_char(rep);
            end
            else
            begin
                release_questions();
                splice_char(c);
            end
        end
        if (eot)
        begin
            release_questions();
            if (bs_held)
            begin
                emit_char(tlsf_pkg::ChBackslash);
                bs_held = 1'b0;
            end
            if (step_out.size() == 0)
                step_out.push_back('{data: tlsf_pkg::ChNone, has: 1'b0, is_last: 1'b1});
            else
                step_out[step_out.size() - 1].is_last = 1'b1;
            texts_closed++;
        end
        foreach (step_out[i])
            text_due.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: holds an item until accepted, random gaps between items
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            in_byte     <= 8'h00;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                filter_byte(in_byte, end_of_text);
                items_taken++;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!in_valid || in_ready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid    <= 1'b1;
                    in_byte     <= byte_queue[0].data;
                    end_of_text <= byte_queue[0].eot;
                    void'(byte_queue.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, compares each result with the oldest due
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (text_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MaxReports)
                        $display("ERROR unexpected result: byte=%h has=%b last=%b",
                                 out_byte, has_byte, last_out);
                end
                else
                begin
                    due_head = text_due.pop_front();
                    if (out_byte !== due_head.data || has_byte !== due_head.has ||
                        last_out !== due_head.is_last)
                    begin
                        errors++;
                        if (errors <= MaxReports)
                            $display("ERROR result %0d: exp %h/%b/%b got %h/%b/%b",
                                     results_seen, due_head.data, due_head.has,
                                     due_head.is_last, out_byte, has_byte, last_out);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycles, text_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_byte(tlsf_pkg::char_t c, bit eot);
        byte_queue.push_back('{data: c, eot: eot});
    endtask

    task automatic add_string(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], close && (i == s.len() - 1));
    endtask

    // Biased toward question marks, trigraph tails, backslashes and newlines
    function automatic tlsf_pkg::char_t random_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return tlsf_pkg::ChQuestion;
        else if (r < 55)
            return TrigraphTail[$urandom_range(8)];
        else if (r < 65)
            return tlsf_pkg::ChBackslash;
        else if (r < 73)
            return tlsf_pkg::ChNewline;
        else
            return tlsf_pkg::char_t'($urandom_range(255));
    endfunction

    task automatic add_text(int unsigned len, bit close);
        for (int i = 0; i < len; i++)
            add_byte(random_char(), close && (i == len - 1));
    endtask

    // Block is idle: nothing queued, nothing offered, nothing due, pipe drained
    task automatic wait_idle();
        while (byte_queue.size() != 0 || in_valid || text_due.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_switch(bit value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        trig_en = value;
        switch_writes++;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned queued;
        int unsigned len;
        bit          close;
        bit          phase_en [6];

        phase_en = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_switch(1'b1);

        // Directed: replacement, trigraph-made backslash spliced away,
        // long run of question marks, two held without a trigraph,
        // backslash pairs, byte extremes, flush of held characters at the end
        // of a text, bare end marker, held question marks across a switch-off.
        add_string("??=??/\n", 1'b0);
        add_string("????-", 1'b0);
        add_string("??x\\\\", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_string("?\\", 1'b1);
        add_string("\\\n", 1'b1);
        add_string("??", 1'b0);
        wait_idle();
        write_switch(1'b0);
        add_string("x", 1'b1);
        wait_idle();

        // Random phases; the last text of a phase is sometimes left open so
        // held characters meet the next switch setting.
        foreach (phase_en[p])
        begin
            write_switch(phase_en[p]);
            idle_pct = (p == 3) ? 0 : IdlePct;   // one stretch at full rate
            queued = 0;
            while (queued < PhaseItems)
            begin
                len    = ($urandom_range(7) == 0) ? $urandom_range(40, 16) : $urandom_range(12, 1);
                close  = (queued + len < PhaseItems) || (p == 5) || ($urandom_range(1) == 1);
                add_text(len, close);
                queued += len;
            end
            wait_idle();
        end

        if (text_due.size() != 0)
        begin
            errors += text_due.size();
            $display("ERROR %0d predicted results never arrived", text_due.size());
        end
        if (errors > MaxReports)
            $display("%0d further mismatches not shown", errors - MaxReports);

        $display("Covered %0d input items in %0d texts, %0d result items checked",
                 items_taken, texts_closed, results_seen);
        $display("%0d trigraphs replaced, %0d line splices removed, %0d switch writes",
                 trigraphs_hit, splices_cut, switch_writes);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
design/tlsf_pkg.sv
design/trigraph_and_line_splice_filter.sv
tb/testbench.sv
